// File: design/ocl_pkg.sv
`default_nettype none

package ocl_pkg;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int REQ_W   = 4;
  localparam int BLK_W   = 6;
  localparam int WORD_W  = 4;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 7;

  // defaults for the top level parameters
  localparam int DEF_NUM_BLOCKS  = 64;
  localparam int DEF_BLOCK_WORDS = 16;

  // requester ids at or above this count are rejected
  localparam int REQUESTERS = 16;

  localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = CFG_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_LOCK   = 2'd0,
    OP_UNLOCK = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FAIL = 1'b1
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic held;
    logic [REQ_W-1:0] owner;
  } lock_ent_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic capture;
    logic exec;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/ocl_ctrl.sv
`default_nettype none

module ocl_ctrl
  import ocl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: cmd.exec = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: design/ocl_dpath.sv
`default_nettype none

module ocl_dpath
  import ocl_pkg::*;
#(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_WORDS = DEF_BLOCK_WORDS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctl_cmd_t          cmd,
  output dp_stat_t               stat,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [REQ_W-1:0]  in_requester,
  input  wire logic [BLK_W-1:0]  in_block,
  input  wire logic [WORD_W-1:0] in_word_offset,
  input  wire logic [DATA_W-1:0] in_write_data,
  output logic                   out_status,
  output logic [DATA_W-1:0]      out_read_data
);

  localparam int DEPTH = NUM_BLOCKS * BLOCK_WORDS;
  localparam int LK_AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int DA_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lock_ent_t          lock_mem [NUM_BLOCKS];
  logic [DATA_W-1:0]  data_mem [DEPTH];

  logic [CFG_W-1:0]   biu_r;
  logic [DA_AW-1:0]   clr_cnt_r;

  // captured request
  op_t                op_r;
  logic [REQ_W-1:0]   req_r;
  logic [BLK_W-1:0]   blk_r;
  logic [WORD_W-1:0]  word_r;
  logic [DATA_W-1:0]  wdata_r;
  logic [DA_AW-1:0]   addr_r;
  lock_ent_t          lk_rd_r;
  logic [DATA_W-1:0]  da_rd_r;

  logic [LK_AW-1:0]   rd_blk;
  logic [DA_AW-1:0]   rd_addr;
  logic               clr_lock;

  logic               in_range, owned, word_ok, succ;
  logic               lk_we, da_we;
  lock_ent_t          lk_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r     <= BLOCKS_IN_USE_RST;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) biu_r <= cfg_wdata;
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clr_last = (32'(clr_cnt_r) == 32'(DEPTH - 1));
  assign clr_lock      = ({1'b0, clr_cnt_r} < (DA_AW + 1)'(NUM_BLOCKS));

  assign rd_blk  = LK_AW'(in_block);
  assign rd_addr = DA_AW'(32'(in_block) * 32'(BLOCK_WORDS) + 32'(in_word_offset));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(in_op);
      req_r   <= in_requester;
      blk_r   <= in_block;
      word_r  <= in_word_offset;
      wdata_r <= in_write_data;
      addr_r  <= rd_addr;
    end
  end

  // lock table
  always_ff @(posedge clk) begin
    if (cmd.clr_en && clr_lock) begin
      lock_mem[LK_AW'(clr_cnt_r)] <= '0;
    end else if (cmd.exec && lk_we) begin
      lock_mem[LK_AW'(blk_r)] <= lk_wdata;
    end
    if (cmd.capture) lk_rd_r <= lock_mem[rd_blk];
  end

  // block store
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      data_mem[clr_cnt_r] <= '0;
    end else if (cmd.exec && da_we) begin
      data_mem[addr_r] <= wdata_r;
    end
    if (cmd.capture) da_rd_r <= data_mem[rd_addr];
  end

  // owner check
  always_comb begin
    in_range = ({1'b0, blk_r} < biu_r) && (32'(blk_r) < 32'(NUM_BLOCKS)) &&
               (32'(req_r) < 32'(REQUESTERS));
    owned    = lk_rd_r.held && (lk_rd_r.owner == req_r);
    word_ok  = 32'(word_r) < 32'(BLOCK_WORDS);
    lk_wdata = '0;
    lk_we    = 1'b0;
    da_we    = 1'b0;
    succ     = 1'b0;
    case (op_r)
      OP_LOCK: begin
        succ           = in_range && !lk_rd_r.held;
        lk_we          = succ;
        lk_wdata.held  = 1'b1;
        lk_wdata.owner = req_r;
      end
      OP_UNLOCK: begin
        succ  = in_range && owned;
        lk_we = succ;
      end
      OP_READ:  succ = in_range && owned && word_ok;
      OP_WRITE: begin
        succ  = in_range && owned && word_ok;
        da_we = succ;
      end
      default: succ = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status    <= succ ? STATUS_OK : STATUS_FAIL;
      out_read_data <= (succ && op_r == OP_READ) ? da_rd_r : '0;
    end
  end

endmodule

`default_nettype wire

// File: design/owner_checked_lock_table.sv
`default_nettype none

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_op, in_requester, in_block,
//                                             in_word_offset, in_write_data
// out       output     out_valid / out_ready  out_status, out_read_data
// cfg       input      cfg_we (no wait)       cfg_wdata -> blocks_in_use
//
// on accept an item reads the lock table and the block store (registered read
// ports); the check step then checks the owner, writes back and loads the
// result register
// after reset a clearing pass zeroes locks and data, one store word a cycle,
// over all NUM_BLOCKS * BLOCK_WORDS words (1024 by default) with in_ready low
// a result waiting on out_ready does not block the next accept; the check of
// that next item waits until the result register frees up

module owner_checked_lock_table
  import ocl_pkg::*;
#(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_WORDS = DEF_BLOCK_WORDS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  // request items
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [REQ_W-1:0]  in_requester,
  input  wire logic [BLK_W-1:0]  in_block,
  input  wire logic [WORD_W-1:0] in_word_offset,
  input  wire logic [DATA_W-1:0] in_write_data,
  // result items
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_status,
  output logic [DATA_W-1:0]      out_read_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing: clear pass, accept, check and write back
  ocl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // lock table, block store, owner check and result register
  ocl_dpath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_op),
    .in_requester   (in_requester),
    .in_block       (in_block),
    .in_word_offset (in_word_offset),
    .in_write_data  (in_write_data),
    .out_status     (out_status),
    .out_read_data  (out_read_data)
  );

  // clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request accepted during clearing pass");

  // one item in flight: no accept on the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // a failed request never returns data
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_FAIL) |-> (out_read_data == '0))
    else $error("failed item carries read data");

  // an item is checked only once the result register can take it
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
    else $error("result missing after accept");

endmodule

`default_nettype wire
